@@ design/d3cs_pkg.sv @@
// Shared types and constants of the 3D copy splitter.
`timescale 1ns / 1ps

package d3cs_pkg;

   // Number of cores that share the partitioned dimension.
   localparam int CORE_COUNT = 8;

   // The middle-length division works on the 16-bit byte total.
   localparam int DIV_W     = 16;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_COPY_MODE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CORE_INDEX = 1'd1;

   localparam logic [1:0] MODE_ROW       = 2'd0;
   localparam logic [1:0] MODE_PLANE     = 2'd1;
   localparam logic [1:0] MODE_TRANSPOSE = 2'd2;
   localparam logic [1:0] MODE_WHOLE     = 2'd3;

   localparam logic KIND_NEW  = 1'b0;
   localparam logic KIND_NEXT = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [31:0] remote_base;
      logic [31:0] local_base;
      logic [15:0] total_bytes;
      logic [15:0] plane_stride;
      logic [15:0] row_stride;
      logic [15:0] outer_length;
      logic [15:0] inner_length;
      logic        direction;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [31:0] remote_addr;
      logic [31:0] local_addr;
      logic [15:0] byte_count;
      logic        dir_out;
      logic        two_d;
      logic [15:0] two_d_stride;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] a;
      logic [15:0] b;
   } mul_op_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [31:0]      divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_res_type;

endpackage

@@ design/d3cs_mul.sv @@
// Shared multiplier with a registered product, truncated to 32 bits.
`timescale 1ns / 1ps

module d3cs_mul (
   input  logic                 clock,
   input  d3cs_pkg::mul_op_type op,
   output logic [31:0]          prod
);

   logic [47:0] full;
   logic [31:0] prod_ff;
   logic [31:0] prod_in;

   assign full    = op.a * op.b;
   assign prod_in = full[31:0];
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ design/d3cs_div.sv @@
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module d3cs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  d3cs_pkg::div_cmd_type cmd,
   output d3cs_pkg::div_res_type res
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [d3cs_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [d3cs_pkg::DIV_W-1:0]     rem_ff, rem_in;
   logic [d3cs_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [31:0]                   dsr_ff, dsr_in;
   logic [d3cs_pkg::DIV_W:0]       shifted;
   logic [31:0]                   diff;
   logic                          fits;

   assign shifted = {rem_ff, quo_ff[d3cs_pkg::DIV_W-1]};
   assign fits    = 32'(shifted) >= dsr_ff;
   assign diff    = 32'(shifted) - dsr_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (cmd.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = d3cs_pkg::DIV_CNT_W'(d3cs_pkg::DIV_W);
         rem_in  = '0;
         quo_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
      end else if (busy_ff) begin
         // The partial remainder never exceeds the dividend bits seen so far.
         rem_in = fits ? diff[d3cs_pkg::DIV_W-1:0] : shifted[d3cs_pkg::DIV_W-1:0];
         quo_in = {quo_ff[d3cs_pkg::DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == d3cs_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;

endmodule

@@ design/dma_3d_copy_splitter.sv @@
// Top level of the 3D copy splitter: request sequencer, index state and result register.
`timescale 1ns / 1ps

// Every accepted request gives exactly one result. A new copy request (kind 0) keeps the
// request side stalled while the shared multiplier forms the divisor, the shared divider
// works out the middle length, and the shared multiplier then forms the range start, the
// transfer size and the first descriptor. A next-descriptor request (kind 1) keeps it
// stalled while the shared multiplier computes, one per cycle, the up to four products
// for the addresses of a descriptor (per-row mode needs all four, per-plane two,
// transpose one), and while the output register is loaded. Mode 3 skips the division; a
// zero divisor or an empty range ends the request with an empty result, as does a
// next-descriptor request with nothing pending. The request side stalls while a request
// is being worked on; a finished result waits in the output register without blocking
// the next request, and a result that finds that register still full holds the request
// side until it drains. The user must write the configuration registers only while the
// block is idle; the block itself does not enforce this.
module dma_3d_copy_splitter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  d3cs_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output d3cs_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [d3cs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [d3cs_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_PROD   = 4'd1;
   localparam logic [3:0] ST_DIV    = 4'd2;
   localparam logic [3:0] ST_DIVW   = 4'd3;
   localparam logic [3:0] ST_CHUNKW = 4'd4;
   localparam logic [3:0] ST_RANGE  = 4'd5;
   localparam logic [3:0] ST_SIZE   = 4'd6;
   localparam logic [3:0] ST_SIZEW  = 4'd7;
   localparam logic [3:0] ST_EMA    = 4'd8;
   localparam logic [3:0] ST_EMB    = 4'd9;
   localparam logic [3:0] ST_EMC    = 4'd10;
   localparam logic [3:0] ST_EMD    = 4'd11;
   localparam logic [3:0] ST_EME    = 4'd12;
   localparam logic [3:0] ST_OUT    = 4'd13;

   logic [3:0]  state_ff, state_in;
   logic        active_ff, active_in;
   logic [1:0]  cfg_mode_ff, cfg_mode_in;
   logic [2:0]  cfg_core_ff, cfg_core_in;

   // Saved request.
   logic [31:0] rbase_ff, rbase_in;
   logic [31:0] lbase_ff, lbase_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] plane_ff, plane_in;
   logic [15:0] rowstr_ff, rowstr_in;
   logic [15:0] outer_len_ff, outer_len_in;
   logic [15:0] inner_len_ff, inner_len_in;
   logic        dir_ff, dir_in;
   logic [1:0]  mode_ff, mode_in;

   // Walk state.
   logic [15:0] oidx_ff, oidx_in;
   logic [15:0] ridx_ff, ridx_in;
   logic [15:0] stop_ff, stop_in;
   logic [15:0] middle_ff, middle_in;
   logic [15:0] chunk_ff, chunk_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] rem_acc_ff, rem_acc_in;

   d3cs_pkg::rsp_type res_ff, res_in;
   d3cs_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   d3cs_pkg::rsp_type empty_rsp;

   d3cs_pkg::mul_op_type  mul_op;
   logic [31:0]           prod;
   d3cs_pkg::div_cmd_type div_cmd;
   d3cs_pkg::div_res_type div_res;

   logic [15:0] span;
   logic [16:0] span_sum;
   logic [15:0] chunk_v;
   logic [15:0] start_v;
   logic [16:0] stop_sum;
   logic [15:0] stop_v;
   logic        empty_range;
   logic [16:0] oidx_inc;
   logic [16:0] ridx_inc;
   logic        row_wrap;
   logic [16:0] oidx_new;
   logic        walk_done;

   d3cs_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod)
   );

   d3cs_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      empty_rsp      = '0;
      empty_rsp.last = 1'b1;
   end

   assign span = (mode_ff == d3cs_pkg::MODE_TRANSPOSE) ? inner_len_ff : outer_len_ff;

   // The core count is a power of two, so the ceiling chunk is an add and a shift.
   assign span_sum = {1'b0, span} + 17'(d3cs_pkg::CORE_COUNT - 1);
   assign chunk_v  = 16'(span_sum / 17'(d3cs_pkg::CORE_COUNT));

   // In the range state the multiplier holds chunk * core_index.
   assign start_v     = (prod >= 32'(span)) ? span : prod[15:0];
   assign stop_sum    = {1'b0, start_v} + {1'b0, chunk_ff};
   assign stop_v      = (stop_sum >= {1'b0, span}) ? span : stop_sum[15:0];
   assign empty_range = (start_v >= stop_v)
                        || ((mode_ff == d3cs_pkg::MODE_ROW) && (middle_ff == 16'd0));

   assign oidx_inc  = {1'b0, oidx_ff} + 17'd1;
   assign ridx_inc  = {1'b0, ridx_ff} + 17'd1;
   assign row_wrap  = ridx_inc >= {1'b0, middle_ff};
   assign oidx_new  = ((mode_ff != d3cs_pkg::MODE_ROW) || row_wrap) ? oidx_inc
                                                                    : {1'b0, oidx_ff};
   assign walk_done = oidx_new >= {1'b0, stop_ff};

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      cfg_mode_in  = cfg_mode_ff;
      cfg_core_in  = cfg_core_ff;
      rbase_in     = rbase_ff;
      lbase_in     = lbase_ff;
      total_in     = total_ff;
      plane_in     = plane_ff;
      rowstr_in    = rowstr_ff;
      outer_len_in = outer_len_ff;
      inner_len_in = inner_len_ff;
      dir_in       = dir_ff;
      mode_in      = mode_ff;
      oidx_in      = oidx_ff;
      ridx_in      = ridx_ff;
      stop_in      = stop_ff;
      middle_in    = middle_ff;
      chunk_in     = chunk_ff;
      size_in      = size_ff;
      rem_acc_in   = rem_acc_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_op       = '0;
      div_cmd      = '0;

      if (csr_valid) begin
         unique case (csr_index)
            d3cs_pkg::REG_COPY_MODE:  cfg_mode_in = csr_data[1:0];
            d3cs_pkg::REG_CORE_INDEX: cfg_core_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.kind == d3cs_pkg::KIND_NEW) begin
                  rbase_in     = req_data.remote_base;
                  lbase_in     = req_data.local_base;
                  total_in     = req_data.total_bytes;
                  plane_in     = req_data.plane_stride;
                  rowstr_in    = req_data.row_stride;
                  outer_len_in = req_data.outer_length;
                  inner_len_in = req_data.inner_length;
                  dir_in       = req_data.direction;
                  mode_in      = cfg_mode_ff;
                  active_in    = 1'b0;
                  state_in     = ST_PROD;
               end else if (active_ff) begin
                  state_in = ST_EMA;
               end else begin
                  res_in   = empty_rsp;
                  state_in = ST_OUT;
               end
            end
         end
         ST_PROD: begin
            mul_op.a = 32'(outer_len_ff);
            mul_op.b = inner_len_ff;
            if (mode_ff == d3cs_pkg::MODE_WHOLE) begin
               // The whole copy belongs to core 0 alone.
               if (cfg_core_ff != 3'd0) begin
                  res_in = empty_rsp;
               end else begin
                  res_in.valid_res    = 1'b1;
                  res_in.remote_addr  = rbase_ff;
                  res_in.local_addr   = lbase_ff;
                  res_in.byte_count   = total_ff;
                  res_in.dir_out      = dir_ff;
                  res_in.two_d        = 1'b0;
                  res_in.two_d_stride = 16'd0;
                  res_in.last         = 1'b1;
               end
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (prod == 32'd0) begin
               res_in   = empty_rsp;
               state_in = ST_OUT;
            end else begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = d3cs_pkg::DIV_W'(total_ff);
               div_cmd.divisor  = prod;
               state_in         = ST_DIVW;
            end
         end
         ST_DIVW: begin
            if (div_res.done) begin
               middle_in = div_res.quotient[15:0];
               chunk_in  = chunk_v;
               state_in  = ST_CHUNKW;
            end
         end
         ST_CHUNKW: begin
            mul_op.a = 32'(chunk_ff);
            mul_op.b = 16'(cfg_core_ff);
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            if (empty_range) begin
               res_in   = empty_rsp;
               state_in = ST_OUT;
            end else begin
               oidx_in   = start_v;
               stop_in   = stop_v;
               ridx_in   = 16'd0;
               active_in = 1'b1;
               state_in  = ST_SIZE;
            end
         end
         ST_SIZE: begin
            mul_op.a = 32'(middle_ff);
            mul_op.b = (mode_ff == d3cs_pkg::MODE_TRANSPOSE) ? outer_len_ff : inner_len_ff;
            state_in = ST_SIZEW;
         end
         ST_SIZEW: begin
            size_in  = prod;
            state_in = ST_EMA;
         end
         ST_EMA: begin
            if (mode_ff == d3cs_pkg::MODE_TRANSPOSE) begin
               mul_op.a = size_ff;
               mul_op.b = oidx_ff;
               state_in = ST_EME;
            end else begin
               mul_op.a = 32'(oidx_ff);
               mul_op.b = plane_ff;
               state_in = ST_EMB;
            end
         end
         ST_EMB: begin
            rem_acc_in = prod;
            if (mode_ff == d3cs_pkg::MODE_ROW) begin
               mul_op.a = 32'(ridx_ff);
               mul_op.b = rowstr_ff;
               state_in = ST_EMC;
            end else begin
               mul_op.a = size_ff;
               mul_op.b = oidx_ff;
               state_in = ST_EME;
            end
         end
         ST_EMC: begin
            rem_acc_in = rem_acc_ff + prod;
            mul_op.a   = 32'(oidx_ff);
            mul_op.b   = middle_ff;
            state_in   = ST_EMD;
         end
         ST_EMD: begin
            // Row offset within the local buffer, in rows, times the row length.
            mul_op.a = prod + 32'(ridx_ff);
            mul_op.b = inner_len_ff;
            state_in = ST_EME;
         end
         ST_EME: begin
            res_in.valid_res   = 1'b1;
            res_in.remote_addr = rbase_ff + ((mode_ff == d3cs_pkg::MODE_TRANSPOSE)
                                             ? 32'(oidx_ff) : rem_acc_ff);
            res_in.local_addr  = lbase_ff + prod;
            res_in.byte_count  = (mode_ff == d3cs_pkg::MODE_ROW) ? inner_len_ff
                                                                 : size_ff[15:0];
            res_in.dir_out      = dir_ff;
            res_in.two_d        = (mode_ff == d3cs_pkg::MODE_TRANSPOSE);
            res_in.two_d_stride = (mode_ff == d3cs_pkg::MODE_TRANSPOSE) ? rowstr_ff : 16'd0;
            res_in.last         = walk_done;
            if ((mode_ff == d3cs_pkg::MODE_ROW) && !row_wrap) begin
               ridx_in = ridx_inc[15:0];
            end else begin
               ridx_in = 16'd0;
            end
            oidx_in = oidx_new[15:0];
            if (walk_done) begin
               active_in = 1'b0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         cfg_mode_ff  <= 2'd0;
         cfg_core_ff  <= 3'd0;
         rsp_valid_ff <= 1'b0;
         oidx_ff      <= 16'd0;
         ridx_ff      <= 16'd0;
         stop_ff      <= 16'd0;
         middle_ff    <= 16'd0;
         mode_ff      <= 2'd0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         cfg_mode_ff  <= cfg_mode_in;
         cfg_core_ff  <= cfg_core_in;
         rsp_valid_ff <= rsp_valid_in;
         oidx_ff      <= oidx_in;
         ridx_ff      <= ridx_in;
         stop_ff      <= stop_in;
         middle_ff    <= middle_in;
         mode_ff      <= mode_in;
      end
      rbase_ff     <= rbase_in;
      lbase_ff     <= lbase_in;
      total_ff     <= total_in;
      plane_ff     <= plane_in;
      rowstr_ff    <= rowstr_in;
      outer_len_ff <= outer_len_in;
      inner_len_ff <= inner_len_in;
      dir_ff       <= dir_in;
      chunk_ff     <= chunk_in;
      size_ff      <= size_in;
      rem_acc_ff   <= rem_acc_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.valid_res) |-> rsp_ff.last)
      else $error("result without a descriptor is not marked last");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && active_ff) |-> (oidx_ff < stop_ff))
      else $error("active walk has run past its stop index");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) && active_ff && (mode_ff == d3cs_pkg::MODE_ROW))
      |-> (ridx_ff < middle_ff))
      else $error("row index has reached the middle length");

endmodule
